// File: sv/voice_mixer_with_soft_limiter_assert.svh
// assertion macros for the voice mixer checker
// expects clk and arst_n to be visible where a macro is used
`ifndef VOICE_MIXER_WITH_SOFT_LIMITER_ASSERT_SVH
`define VOICE_MIXER_WITH_SOFT_LIMITER_ASSERT_SVH

// same-cycle implication
`define VML_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("vml check failed");

// next-cycle implication
`define VML_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("vml check failed");

`endif

// File: sv/vml_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and record types for the voice mixer
// no dependencies
package vml_pkg;

	localparam int SAMPLE_DEPTH = 1048576;
	localparam int SAMPLE_AW    = $clog2(SAMPLE_DEPTH);
	localparam int VOICE_COUNT  = 16;
	localparam int VOICE_AW     = $clog2(VOICE_COUNT);
	localparam int SOUND_COUNT  = 128;
	localparam int SOUND_AW     = $clog2(SOUND_COUNT);

	localparam int ADDR_W = 20;
	localparam int LEN_W  = 21;
	localparam int TIME_W = 48;
	localparam int SMP_W  = 16;
	localparam int CNT_W  = 5;
	localparam int ACC_W  = SMP_W + $clog2(VOICE_COUNT + 1);

	// divider sizes for the source-count scaling
	localparam int DIV_NW = ACC_W + 10;
	localparam int DIV_DW = $clog2(1024 + VOICE_COUNT * 480 + 1);

	localparam logic [LEN_W-1:0]  MAX_FRAMES = LEN_W'(1048576);
	localparam logic [TIME_W-1:0] RETRIG_US  = TIME_W'(14000);
	localparam int                FADE_LEN   = 48;
	localparam int                KNEE       = 28000;
	localparam int                PEAK       = 32767;

	// reciprocals: x/3 = (x*RECIP3)>>20 for x < 2^19, x/5 = (x*RECIP5)>>22 for x < 2^22
	localparam logic [18:0] RECIP3 = 19'd349526;
	localparam int          RECIP3_SH = 20;
	localparam logic [19:0] RECIP5 = 20'd838861;
	localparam int          RECIP5_SH = 22;

	localparam logic [2:0] CMD_WRITE       = 3'd0;
	localparam logic [2:0] CMD_DEFINE      = 3'd1;
	localparam logic [2:0] CMD_PLAY        = 3'd2;
	localparam logic [2:0] CMD_MUSIC_START = 3'd3;
	localparam logic [2:0] CMD_MUSIC_STOP  = 3'd4;
	localparam logic [2:0] CMD_TICK        = 3'd5;

	localparam logic CFG_MUSIC_ADDR   = 1'b0;
	localparam logic CFG_MUSIC_FRAMES = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0]  length;
		logic [TIME_W-1:0] last_play;
		logic              played;
	} entry_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [LEN_W-1:0]  length;
		logic [LEN_W-1:0]  position;
	} voice_t;

	function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
		return (v > MAX_FRAMES) ? MAX_FRAMES : v;
	endfunction

endpackage

// File: sv/voice_mixer_with_soft_limiter.sv
`timescale 1ns / 1ps
// Sixteen-voice PCM mixer over a 1M-word sample ram with a sound table, voice stealing and a
// soft limiter. Sample writes, sound definitions and music start/stop finish in the idle state.
// A play reads the sound table; with an idle voice free it starts that voice, and when every
// voice is busy the voice ram is first walked one voice at a time to find the one nearest its
// end. A tick reads the music sample when music is on, then walks the voice ram; with more
// than one source the bit-serial scaling divider runs, followed by the limiter and the output
// register. A tick ends later while an earlier result still waits on a stalled output.
// The block takes a new command once the previous one has finished, while a result still
// waits in the output register. There is no clearing pass after reset.
module voice_mixer_with_soft_limiter import vml_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [2:0]               cmd,
	input  logic [ADDR_W-1:0]        address,
	input  logic signed [SMP_W-1:0]  sample_value,
	input  logic [6:0]               sound_index,
	input  logic [LEN_W-1:0]         sound_length,
	input  logic [TIME_W-1:0]        now_us,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [SMP_W-1:0]  mixed_sample,
	output logic [CNT_W-1:0]         source_count,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_index,
	input  logic [LEN_W-1:0]         cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_PLAY_CHK, S_SCAN_RD, S_SCAN_EV, S_VSTART,
		S_MUS_RD, S_V_RD, S_V_EV, S_V_SMP, S_V_DIV, S_V_ACC,
		S_SCALE, S_DIV_WAIT, S_LIM1, S_LIM2, S_OUT
	} state_t;

	state_t                  state_q;
	logic [ADDR_W-1:0]       music_addr_q;
	logic [LEN_W-1:0]        music_frames_q;
	logic                    music_on_q;
	logic [LEN_W-1:0]        music_pos_q;
	logic [SOUND_COUNT-1:0]  ent_vld_q;
	logic                    ent_vld_s1;
	logic [VOICE_COUNT-1:0]  busy_q;
	logic [SOUND_AW-1:0]     idx_q;
	logic [TIME_W-1:0]       now_q;
	logic [ADDR_W-1:0]       ent_start_q;
	logic [LEN_W-1:0]        ent_len_q;
	logic [VOICE_AW-1:0]     vidx_q;
	logic [LEN_W-1:0]        least_q;
	logic [VOICE_AW-1:0]     best_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0]        n_q;
	logic [LEN_W-1:0]        left_q;
	logic                    fade_q;
	logic signed [22:0]      prod_q;
	logic signed [SMP_W:0]   term_q;
	logic [ACC_W-1:0]        mag_q;
	logic                    neg_q;
	logic                    knee_q;
	logic [ACC_W+19:0]       kprod_q;
	logic signed [SMP_W-1:0] lim_q;
	logic                    out_valid_q;
	logic signed [SMP_W-1:0] out_sample_q;
	logic [CNT_W-1:0]        out_count_q;

	logic                    in_acc;
	logic [LEN_W-1:0]        mpos;
	logic                    music_live;
	logic                    smp_we;
	logic [SAMPLE_AW-1:0]    smp_raddr;
	logic [SMP_W-1:0]        smp_rdata;
	logic                    ent_we;
	logic [SOUND_AW-1:0]     ent_waddr;
	entry_t                  ent_wdata;
	logic [$bits(entry_t)-1:0] ent_rdata;
	entry_t                  er;
	logic                    play_ok;
	logic                    voc_we;
	voice_t                  voc_wdata;
	logic [$bits(voice_t)-1:0] voc_rdata;
	voice_t                  vr;
	logic                    v_busy;
	logic                    v_live;
	logic [LEN_W-1:0]        p_next;
	logic [LEN_W-1:0]        scan_left;
	logic                    any_idle;
	logic [VOICE_AW-1:0]     first_idle;
	logic signed [SMP_W+1:0] mus3;
	logic signed [SMP_W-1:0] mus_term;
	logic [21:0]             fmag;
	logic [37:0]             fq;
	logic [ACC_W-1:0]        acc_mag;
	logic                    div_start;
	logic [DIV_NW-1:0]       div_quo;
	logic                    div_done;
	logic [DIV_DW-1:0]       divisor;
	logic [ACC_W-1:0]        knee_y;
	logic [ACC_W+19:0]       kmul;
	logic [ACC_W-1:0]        kval;
	logic [SMP_W-1:0]        lim_mag;

	assign in_acc     = in_valid && !in_stall;
	assign in_stall   = (state_q != S_IDLE);
	assign cfg_ready  = 1'b1;
	assign music_live = music_on_q && (music_frames_q != '0);

	always_comb begin
		mpos = (music_pos_q >= music_frames_q) ? '0 : music_pos_q;
		er   = ent_vld_s1 ? entry_t'(ent_rdata) : '0;
		vr   = voice_t'(voc_rdata);
		v_busy    = busy_q[vidx_q];
		v_live    = v_busy && (vr.position < vr.length);
		p_next    = vr.position + 1'b1;
		scan_left = (vr.position < vr.length) ? (vr.length - vr.position) : '0;
		play_ok   = (er.length != '0) &&
		            !(er.played && ((now_q - er.last_play) < RETRIG_US));
		any_idle   = ~&busy_q;
		first_idle = '0;
		for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
			if (!busy_q[v]) begin
				first_idle = VOICE_AW'(v);
			end
		end
		// music at 3/8, rounded toward zero
		mus3     = $signed(smp_rdata) * 18'sd3;
		mus_term = SMP_W'((mus3 + (mus3 < 0 ? 18'sd7 : 18'sd0)) >>> 3);
		// fade: |s*left| / 48 as (x>>4)/3
		fmag = prod_q[22] ? 22'(-prod_q) : prod_q[21:0];
		fq   = 38'(fmag[21:4]) * 38'(RECIP3);
		acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		divisor = DIV_DW'(1024 + (int'(n_q) - 1) * 480);
		knee_y  = mag_q - ACC_W'(KNEE);
		kmul    = (ACC_W+20)'(knee_y) * (ACC_W+20)'(RECIP5);
		kval    = ACC_W'(KNEE) + ACC_W'(kprod_q >> RECIP5_SH);
		lim_mag = knee_q ? ((kval > ACC_W'(PEAK)) ? SMP_W'(PEAK) : kval[SMP_W-1:0])
		                 : mag_q[SMP_W-1:0];
	end

	// sample ram ports
	always_comb begin
		smp_we = in_acc && (cmd == CMD_WRITE);
		if (state_q == S_IDLE) begin
			smp_raddr = SAMPLE_AW'(music_addr_q + ADDR_W'(mpos));
		end else begin
			smp_raddr = SAMPLE_AW'(vr.base + ADDR_W'(vr.position));
		end
	end

	// sound table ports
	always_comb begin
		if (state_q == S_PLAY_CHK) begin
			ent_we    = play_ok;
			ent_waddr = idx_q;
			ent_wdata = '{start: er.start, length: er.length, last_play: now_q, played: 1'b1};
		end else begin
			ent_we    = in_acc && (cmd == CMD_DEFINE) && (int'(sound_index) < SOUND_COUNT);
			ent_waddr = SOUND_AW'(sound_index);
			ent_wdata = '{start: address, length: sat_len(sound_length),
			              last_play: '0, played: 1'b0};
		end
	end

	// voice ram ports
	always_comb begin
		if (state_q == S_VSTART) begin
			voc_we    = 1'b1;
			voc_wdata = '{base: ent_start_q, length: ent_len_q, position: '0};
		end else begin
			voc_we    = (state_q == S_V_EV) && v_live;
			voc_wdata = '{base: vr.base, length: vr.length, position: p_next};
		end
	end

	assign div_start = (state_q == S_SCALE) && (n_q > CNT_W'(1));

	vml_ram #(.WIDTH(SMP_W), .DEPTH(SAMPLE_DEPTH)) u_smp_ram (
		.clk   (clk),
		.we    (smp_we),
		.waddr (SAMPLE_AW'(address)),
		.wdata (sample_value),
		.raddr (smp_raddr),
		.rdata (smp_rdata)
	);

	vml_ram #(.WIDTH($bits(entry_t)), .DEPTH(SOUND_COUNT)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (SOUND_AW'(sound_index)),
		.rdata (ent_rdata)
	);

	vml_ram #(.WIDTH($bits(voice_t)), .DEPTH(VOICE_COUNT)) u_voc_ram (
		.clk   (clk),
		.we    (voc_we),
		.waddr (vidx_q),
		.wdata (voc_wdata),
		.raddr (vidx_q),
		.rdata (voc_rdata)
	);

	vml_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DIV_NW'({acc_mag, 10'd0})),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			music_addr_q   <= '0;
			music_frames_q <= '0;
			music_on_q     <= 1'b0;
			music_pos_q    <= '0;
			ent_vld_q      <= '0;
			busy_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_MUSIC_ADDR:   music_addr_q   <= cfg_data[ADDR_W-1:0];
					CFG_MUSIC_FRAMES: music_frames_q <= sat_len(cfg_data);
					default: ;
				endcase
			end
			if (state_q == S_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (cmd)
							CMD_DEFINE: begin
								if (int'(sound_index) < SOUND_COUNT) begin
									ent_vld_q[SOUND_AW'(sound_index)] <= 1'b1;
								end
							end
							CMD_PLAY: begin
								if (int'(sound_index) < SOUND_COUNT) begin
									ent_vld_s1 <= ent_vld_q[SOUND_AW'(sound_index)];
									idx_q      <= SOUND_AW'(sound_index);
									now_q      <= now_us;
									state_q    <= S_PLAY_CHK;
								end
							end
							CMD_MUSIC_START: begin
								if (music_frames_q != '0) begin
									music_on_q <= 1'b1;
								end
							end
							CMD_MUSIC_STOP: begin
								music_on_q  <= 1'b0;
								music_pos_q <= '0;
							end
							CMD_TICK: begin
								vidx_q <= '0;
								acc_q  <= '0;
								if (music_live) begin
									music_pos_q <= mpos + 1'b1;
									n_q         <= CNT_W'(1);
									state_q     <= S_MUS_RD;
								end else begin
									n_q     <= '0;
									state_q <= S_V_RD;
								end
							end
							default: ;
						endcase
					end
				end
				S_PLAY_CHK: begin
					ent_start_q <= er.start;
					ent_len_q   <= er.length;
					if (!play_ok) begin
						state_q <= S_IDLE;
					end else if (any_idle) begin
						vidx_q  <= first_idle;
						state_q <= S_VSTART;
					end else begin
						vidx_q  <= '0;
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_EV;
				S_SCAN_EV: begin
					// lowest voice wins ties
					if (vidx_q == '0 || scan_left < least_q) begin
						least_q <= scan_left;
						best_q  <= vidx_q;
					end
					if (vidx_q == VOICE_AW'(VOICE_COUNT - 1)) begin
						if (vidx_q == '0 || scan_left < least_q) begin
							vidx_q <= vidx_q;
						end else begin
							vidx_q <= best_q;
						end
						state_q <= S_VSTART;
					end else begin
						vidx_q  <= vidx_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_VSTART: begin
					busy_q[vidx_q] <= 1'b1;
					state_q        <= S_IDLE;
				end
				S_MUS_RD: begin
					acc_q   <= ACC_W'(mus_term);
					state_q <= S_V_RD;
				end
				S_V_RD: state_q <= S_V_EV;
				S_V_EV: begin
					if (v_live) begin
						left_q <= vr.length - p_next;
						fade_q <= (vr.length - p_next) < LEN_W'(FADE_LEN);
						if (p_next >= vr.length) begin
							busy_q[vidx_q] <= 1'b0;
						end
						state_q <= S_V_SMP;
					end else begin
						if (v_busy) begin
							busy_q[vidx_q] <= 1'b0;
						end
						if (vidx_q == VOICE_AW'(VOICE_COUNT - 1)) begin
							state_q <= S_SCALE;
						end else begin
							vidx_q  <= vidx_q + 1'b1;
							state_q <= S_V_RD;
						end
					end
				end
				S_V_SMP: begin
					if (fade_q) begin
						prod_q <= $signed(smp_rdata) * $signed({1'b0, left_q[5:0]});
					end else begin
						prod_q <= 23'($signed(smp_rdata));
					end
					state_q <= S_V_DIV;
				end
				S_V_DIV: begin
					if (fade_q) begin
						term_q <= prod_q[22] ? -(SMP_W+1)'(fq >> RECIP3_SH)
						                     : (SMP_W+1)'(fq >> RECIP3_SH);
					end else begin
						term_q <= prod_q[SMP_W:0];
					end
					state_q <= S_V_ACC;
				end
				S_V_ACC: begin
					acc_q <= acc_q + ACC_W'(term_q);
					n_q   <= n_q + 1'b1;
					if (vidx_q == VOICE_AW'(VOICE_COUNT - 1)) begin
						state_q <= S_SCALE;
					end else begin
						vidx_q  <= vidx_q + 1'b1;
						state_q <= S_V_RD;
					end
				end
				S_SCALE: begin
					neg_q <= acc_q[ACC_W-1];
					if (n_q > CNT_W'(1)) begin
						state_q <= S_DIV_WAIT;
					end else begin
						mag_q   <= acc_mag;
						state_q <= S_LIM1;
					end
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						mag_q   <= div_quo[ACC_W-1:0];
						state_q <= S_LIM1;
					end
				end
				S_LIM1: begin
					knee_q  <= mag_q > ACC_W'(KNEE);
					kprod_q <= kmul;
					state_q <= S_LIM2;
				end
				S_LIM2: begin
					lim_q   <= neg_q ? -$signed(lim_mag) : $signed(lim_mag);
					state_q <= S_OUT;
				end
				S_OUT: begin
					// the held beat keeps its payload until it leaves
					if (!out_valid_q || !out_stall) begin
						out_sample_q <= lim_q;
						out_count_q  <= n_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign mixed_sample = out_sample_q;
	assign source_count = out_count_q;

endmodule

// File: sv/vml_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module vml_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/vml_div.sv
`timescale 1ns / 1ps
// restoring unsigned divider, one quotient bit per cycle
// depends on vml_pkg
module vml_div import vml_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output logic              done,
	output logic [DIV_NW-1:0] quotient
);

	localparam int CW = $clog2(DIV_NW + 1);

	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] dsr_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic [DIV_DW:0]   diff;
	logic              qbit;

	always_comb begin
		trial = {rem_q, quo_q[DIV_NW-1]};
		diff  = trial - {1'b0, dsr_q};
		qbit  = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NW-2:0], qbit};
			rem_q <= qbit ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: sv/vml_chk.sv
`timescale 1ns / 1ps
// port-level checker for the voice mixer, bound to the top level
// depends on vml_pkg and the assertion macro header
`include "voice_mixer_with_soft_limiter_assert.svh"
module vml_chk import vml_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic [2:0]              cmd,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [SMP_W-1:0] mixed_sample,
	input logic [CNT_W-1:0]        source_count
);

	// a held result beat keeps its payload
	`VML_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(mixed_sample) && $stable(source_count))
	// never more sources than voices plus music
	`VML_ASSERT_IMP(a_count_range, out_valid, source_count <= CNT_W'(VOICE_COUNT + 1))
	// only a tick produces a result
	`VML_ASSERT_NXT(a_no_stray_result, in_valid && !in_stall && cmd != CMD_TICK && !out_valid, !out_valid)
	// play and tick leave the sequencer busy once accepted
	`VML_ASSERT_NXT(a_busy_after_long_cmd, in_valid && !in_stall && (cmd == CMD_PLAY || cmd == CMD_TICK), in_stall)

endmodule

bind voice_mixer_with_soft_limiter vml_chk u_vml_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.cmd          (cmd),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.mixed_sample (mixed_sample),
	.source_count (source_count)
);
